@@ design/ddwh_pkg.sv @@
// Shared constants and helper functions for the decimal digit weighted hash.
`timescale 1ns / 1ps

package ddwh_pkg;

  localparam int ID_W        = 32;  // identifier width
  localparam int HASH_W      = 4;   // hash width
  localparam int DIG_W       = 4;   // one decimal digit
  localparam int SUM_W       = 10;  // weighted sum, at most 693
  localparam int HALF_W      = 16;  // half-word swap distance
  localparam int SUM_DIGITS  = 8;   // weighted digits of the identifier
  localparam int HASH_DIGITS = 10;  // digits examined for parity
  localparam int SUM_MAX     = 693; // 9 * (19+17+13+11+7+5+3+2)

  localparam int WGT_W = 5;
  localparam int PRD_W = WGT_W + DIG_W;

  // ceil(2^35 / 10): exact reciprocal for any 32-bit dividend
  localparam logic [63:0] DIV10_MAGIC = 64'h0000_0000_CCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // Quotient by ten through reciprocal multiply.
  function automatic logic [ID_W-1:0] div10(input logic [ID_W-1:0] x);
    logic [63:0] prod;
    prod = 64'(x) * DIV10_MAGIC;
    return ID_W'(prod >> DIV10_SHIFT);
  endfunction

  // Remainder from dividend and quotient: x - 8q - 2q.
  function automatic logic [DIG_W-1:0] rem10(input logic [ID_W-1:0] x,
                                             input logic [ID_W-1:0] q);
    logic [ID_W-1:0] diff;
    diff = x - ((q << 3) + (q << 1));
    return diff[DIG_W-1:0];
  endfunction

  // Digit plus one, wrapping nine to zero.
  function automatic logic [DIG_W-1:0] inc10(input logic [DIG_W-1:0] d);
    return (d == DIG_W'(9)) ? '0 : d + DIG_W'(1);
  endfunction

  // Prime weight of identifier digit k (digit 0 heaviest).
  function automatic logic [WGT_W-1:0] digit_weight(input int k);
    logic [WGT_W-1:0] w;
    case (k)
      0:       w = WGT_W'(19);
      1:       w = WGT_W'(17);
      2:       w = WGT_W'(13);
      3:       w = WGT_W'(11);
      4:       w = WGT_W'(7);
      5:       w = WGT_W'(5);
      6:       w = WGT_W'(3);
      7:       w = WGT_W'(2);
      default: w = '0;
    endcase
    return w;
  endfunction

  // Digit k feeds bit j of parity j (group A) or bit 3-j (group B).
  // Group A: digit 0 and odd digits from 3 up.
  function automatic bit in_group_a(input int k);
    return (k == 0) || ((k >= 3) && ((k % 2) == 1));
  endfunction

endpackage

@@ design/ddwh_sum_cell.sv @@
// Weighted-sum cell: peels one decimal digit and folds in the previous one.
`timescale 1ns / 1ps

module ddwh_sum_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        vld_in,
  input  logic [ddwh_pkg::ID_W-1:0]   rest_in,
  input  logic [ddwh_pkg::DIG_W-1:0]  dig_in,
  input  logic [ddwh_pkg::SUM_W-1:0]  acc_in,
  output logic                        vld,
  output logic [ddwh_pkg::ID_W-1:0]   rest,
  output logic [ddwh_pkg::DIG_W-1:0]  dig,
  output logic [ddwh_pkg::SUM_W-1:0]  acc
);

  // weight of the digit peeled by the left neighbor; none for the first cell
  localparam logic [ddwh_pkg::WGT_W-1:0] WGT =
    (IDX == 0) ? '0 : ddwh_pkg::digit_weight(IDX - 1);

  logic [ddwh_pkg::ID_W-1:0]  rest_next;
  logic [ddwh_pkg::DIG_W-1:0] dig_next;
  logic [ddwh_pkg::PRD_W-1:0] term;
  logic [ddwh_pkg::SUM_W-1:0] acc_next;

  always_comb begin
    rest_next = ddwh_pkg::div10(rest_in);
    dig_next  = ddwh_pkg::rem10(rest_in, rest_next);
    term      = ddwh_pkg::PRD_W'(WGT) * ddwh_pkg::PRD_W'(ddwh_pkg::inc10(dig_in));
    acc_next  = acc_in + ddwh_pkg::SUM_W'(term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rest <= rest_next;
      dig  <= dig_next;
      acc  <= acc_next;
    end
  end

endmodule

@@ design/ddwh_par_cell.sv @@
// Parity cell: peels one decimal digit and folds the previous one into its group.
`timescale 1ns / 1ps

module ddwh_par_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        vld_in,
  input  logic [ddwh_pkg::ID_W-1:0]   rest_in,
  input  logic [ddwh_pkg::DIG_W-1:0]  dig_in,
  input  logic [ddwh_pkg::DIG_W-1:0]  xa_in,
  input  logic [ddwh_pkg::DIG_W-1:0]  xb_in,
  output logic                        vld,
  output logic [ddwh_pkg::ID_W-1:0]   rest,
  output logic [ddwh_pkg::DIG_W-1:0]  dig,
  output logic [ddwh_pkg::DIG_W-1:0]  xa,
  output logic [ddwh_pkg::DIG_W-1:0]  xb
);

  localparam bit USE_A = (IDX > 0) && ddwh_pkg::in_group_a(IDX - 1);
  localparam bit USE_B = (IDX > 0) && !ddwh_pkg::in_group_a(IDX - 1);

  logic [ddwh_pkg::ID_W-1:0]  rest_next;
  logic [ddwh_pkg::DIG_W-1:0] dig_next;
  logic [ddwh_pkg::DIG_W-1:0] xa_next;
  logic [ddwh_pkg::DIG_W-1:0] xb_next;

  always_comb begin
    rest_next = ddwh_pkg::div10(rest_in);
    dig_next  = ddwh_pkg::rem10(rest_in, rest_next);
    xa_next   = USE_A ? (xa_in ^ dig_in) : xa_in;
    xb_next   = USE_B ? (xb_in ^ dig_in) : xb_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rest <= rest_next;
      dig  <= dig_next;
      xa   <= xa_next;
      xb   <= xb_next;
    end
  end

endmodule

@@ design/decimal_digit_weighted_hash_top.sv @@
// Top level of the decimal digit weighted hash: two cell chains and an output register.
`timescale 1ns / 1ps

// Decimal digit weighted hash. Takes one 32-bit identifier per cycle and
// returns a registered 4-bit hash for each accepted item. The eight low
// decimal digits of the identifier are each bumped by one (nine wraps to
// zero), weighted by 19, 17, 13, 11, 7, 5, 3, 2 from the least significant
// digit up and summed; the sum's 16-bit halves are swapped (the sum moves to
// bits 25:16), and the ten decimal digits of that word are folded into four
// parity bits, bit 3 being the parity for j=0. Both stages are rows of cells:
// each cell takes one digit off with a multiply-by-reciprocal divide by ten
// and folds in the digit that its left neighbor took off and registered. The
// sum row has 9 cells, the parity row 11, then one output register. The
// rate is one item per clock; the whole pipe, bubbles included, holds
// while a result sits in the output register under stall, and in_stall
// follows that condition combinationally.

module decimal_digit_weighted_hash_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ddwh_pkg::ID_W-1:0]     id_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ddwh_pkg::HASH_W-1:0]   hash_value
);

  localparam int SUM_CELLS = ddwh_pkg::SUM_DIGITS + 1;
  localparam int PAR_CELLS = ddwh_pkg::HASH_DIGITS + 1;
  localparam int PAD_W     = ddwh_pkg::ID_W - ddwh_pkg::SUM_W - ddwh_pkg::HALF_W;

  // global advance: everything moves unless the output is held
  logic advance;

  // sum row, entry 0 is the row's input
  logic                        s_vld  [SUM_CELLS+1];
  logic [ddwh_pkg::ID_W-1:0]   s_rest [SUM_CELLS+1];
  logic [ddwh_pkg::DIG_W-1:0]  s_dig  [SUM_CELLS+1];
  logic [ddwh_pkg::SUM_W-1:0]  s_acc  [SUM_CELLS+1];

  // parity row
  logic                        p_vld  [PAR_CELLS+1];
  logic [ddwh_pkg::ID_W-1:0]   p_rest [PAR_CELLS+1];
  logic [ddwh_pkg::DIG_W-1:0]  p_dig  [PAR_CELLS+1];
  logic [ddwh_pkg::DIG_W-1:0]  p_xa   [PAR_CELLS+1];
  logic [ddwh_pkg::DIG_W-1:0]  p_xb   [PAR_CELLS+1];

  logic [ddwh_pkg::HASH_W-1:0] hash_next;
  logic [ddwh_pkg::DIG_W-1:0]  xa_last;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // ---- weighted sum row ----
  assign s_vld[0]  = in_valid;
  assign s_rest[0] = id_number;
  assign s_dig[0]  = '0;
  assign s_acc[0]  = '0;

  for (genvar i = 0; i < SUM_CELLS; i++) begin : g_sum
    ddwh_sum_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .vld_in  (s_vld[i]),
      .rest_in (s_rest[i]),
      .dig_in  (s_dig[i]),
      .acc_in  (s_acc[i]),
      .vld     (s_vld[i+1]),
      .rest    (s_rest[i+1]),
      .dig     (s_dig[i+1]),
      .acc     (s_acc[i+1])
    );
  end

  // ---- half-word swap: the sum fits the low half, so it lands at bit 16 ----
  assign p_vld[0]  = s_vld[SUM_CELLS];
  assign p_rest[0] = {{PAD_W{1'b0}}, s_acc[SUM_CELLS], {ddwh_pkg::HALF_W{1'b0}}};
  assign p_dig[0]  = '0;
  assign p_xa[0]   = '0;
  assign p_xb[0]   = '0;

  // ---- parity row ----
  for (genvar i = 0; i < PAR_CELLS; i++) begin : g_par
    ddwh_par_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .vld_in  (p_vld[i]),
      .rest_in (p_rest[i]),
      .dig_in  (p_dig[i]),
      .xa_in   (p_xa[i]),
      .xb_in   (p_xb[i]),
      .vld     (p_vld[i+1]),
      .rest    (p_rest[i+1]),
      .dig     (p_dig[i+1]),
      .xa      (p_xa[i+1]),
      .xb      (p_xb[i+1])
    );
  end

  // parity j = xa[j] ^ xb[3-j], placed at hash bit 3-j
  always_comb begin
    xa_last = p_xa[PAR_CELLS];
    for (int j = 0; j < ddwh_pkg::HASH_W; j++) begin
      hash_next[ddwh_pkg::HASH_W-1-j] = xa_last[j] ^ p_xb[PAR_CELLS][ddwh_pkg::HASH_W-1-j];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= p_vld[PAR_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hash_value <= hash_next;
    end
  end

  // ---- checks ----

  // weighted sum never exceeds nine times the weight total
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    s_vld[SUM_CELLS] |-> (s_acc[SUM_CELLS] <= ddwh_pkg::SUM_W'(ddwh_pkg::SUM_MAX)))
    else $error("weighted sum out of range");

  // the first divide-by-ten cell only ever produces decimal digits
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    s_vld[1] |-> (s_dig[1] <= ddwh_pkg::DIG_W'(9)))
    else $error("digit cell produced a non-decimal remainder");

  // every digit of the swapped sum has been consumed by the end of the row
  a_par_drained: assert property (@(posedge clk) disable iff (rst)
    p_vld[PAR_CELLS] |-> (p_rest[PAR_CELLS] == '0))
    else $error("parity row left digits unconsumed");

  // a held result freezes the pipe: the last parity stage must not move
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(p_vld[PAR_CELLS]) && $stable(p_xa[PAR_CELLS]))
    else $error("pipeline moved while output was held");

endmodule

@@ tb/decimal_digit_weighted_hash_top_tb.sv @@
// Self-checking testbench for the decimal digit weighted hash top level.
`timescale 1ns / 1ps

module decimal_digit_weighted_hash_top_tb;

  // Random items after the directed set.
  localparam int RANDOM_ITEMS = 1080;
  // Cycles to wait after the last result.
  localparam int DRAIN_CYCLES = 60;
  // Hard stop for the whole run, far above the slowest legal run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // Prime weight of each identifier digit, least significant digit first.
  localparam int unsigned PRIME_WEIGHT [8] = '{19, 17, 13, 11, 7, 5, 3, 2};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ddwh_pkg::ID_W-1:0]   id_number = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ddwh_pkg::HASH_W-1:0] hash_value;

  // Identifiers still to be offered, and hashes still owed by the block.
  logic [ddwh_pkg::ID_W-1:0]   pending_ids[$];
  logic [ddwh_pkg::HASH_W-1:0] owed_hashes[$];

  int error_count    = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // Sender burst/gap bookkeeping, private to the driver.
  int burst_left = 1;
  int gap_left   = 0;

  decimal_digit_weighted_hash_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .id_number  (id_number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

  always #1 clk = ~clk;

  // Hash of one identifier. Bump each of the eight low digits (nine wraps to
  // zero), weight and sum; swapping the halves of a sum under 2^16 is a plain
  // shift by 16. Then fold the ten decimal digits of that word into four
  // parity bits. Digit 0 and odd digits from 3 up feed bit j of parity j,
  // digit 1 and the even digits from 2 up feed bit 3-j. Parity j=0 lands in bit 3.
  function automatic logic [ddwh_pkg::HASH_W-1:0] weighted_digit_hash(
    input logic [ddwh_pkg::ID_W-1:0] id
  );
    logic [31:0]                 rest;
    logic [31:0]                 digit;
    logic [31:0]                 sum;
    logic [31:0]                 word;
    logic [ddwh_pkg::HASH_W-1:0] hash;
    logic                        parity;
    int                          pick;
    rest = id;
    sum  = '0;
    for (int k = 0; k < 8; k++) begin
      digit = rest % 10;
      rest  = rest / 10;
      digit = (digit + 1) % 10;
      sum   = sum + digit * PRIME_WEIGHT[k];
    end
    word = {sum[15:0], sum[31:16]};
    hash = '0;
    for (int j = 0; j < 4; j++) begin
      rest   = word;
      parity = 1'b0;
      for (int k = 0; k < 10; k++) begin
        digit  = rest % 10;
        rest   = rest / 10;
        pick   = ((k == 0) || ((k >= 3) && (k % 2 == 1))) ? j : 3 - j;
        parity = parity ^ digit[pick];
      end
      hash = {hash[ddwh_pkg::HASH_W-2:0], parity};
    end
    return hash;
  endfunction

  // Identifier built digit by digit. Half the low digits lean to 0, 8 and 9,
  // which sit at the wrap and the extremes of the weighted sum. The top two
  // digits stay at or below 41 so the value fits 32 bits.
  function automatic logic [ddwh_pkg::ID_W-1:0] decimal_id();
    logic [63:0] value;
    logic [63:0] scale;
    int          digit;
    value = 64'($urandom_range(0, 41)) * 64'd100000000;
    scale = 64'd1;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0:       digit = 0;
        1:       digit = $urandom_range(8, 9);
        default: digit = $urandom_range(0, 9);
      endcase
      value = value + 64'(digit) * scale;
      scale = scale * 64'd10;
    end
    return value[ddwh_pkg::ID_W-1:0];
  endfunction

  // Driver. The expectation is taken when the block accepts an item; the
  // next item or a gap is chosen only once the current one has gone, so a
  // stalled payload never changes. Each signal gets one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_hashes.push_back(weighted_digit_hash(id_number));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ids.size() > 0) begin
          in_valid  <= 1'b1;
          id_number <= pending_ids.pop_front();
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // Roughly a third of bursts run straight into the next one.
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: cycles in turn through no stall, light random
  // stall, heavy random stall and a fixed 3-of-7 pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case ((cycle_count / 128) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  // Monitor: every accepted result is checked against the oldest owed hash.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (owed_hashes.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected hash %0h at cycle %0d", hash_value, cycle_count);
        end
      end else begin
        logic [ddwh_pkg::HASH_W-1:0] want;
        want = owed_hashes.pop_front();
        if (hash_value !== want) begin
          mismatch_count = mismatch_count + 1;
          error_count    = error_count + 1;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("hash mismatch at cycle %0d: expected %0h, got %0h",
                     cycle_count, want, hash_value);
          end
        end
      end
    end
  end

  // Cycle count and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decimal_digit_weighted_hash_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    // Directed items: zero, all ones, low digits all nines (every digit
    // wraps, sum zero), all eights (largest sum), digits above the eighth
    // alone (ignored), single digits, and identifiers near the top of range.
    pending_ids.push_back(32'd0);
    pending_ids.push_back(32'hFFFF_FFFF);
    pending_ids.push_back(32'd99999999);
    pending_ids.push_back(32'd88888888);
    pending_ids.push_back(32'd4288888888);
    pending_ids.push_back(32'd4199999999);
    pending_ids.push_back(32'd100000000);
    pending_ids.push_back(32'd4200000000);
    pending_ids.push_back(32'd1);
    pending_ids.push_back(32'd9);
    pending_ids.push_back(32'd10);
    pending_ids.push_back(32'd90);
    pending_ids.push_back(32'd12345678);
    pending_ids.push_back(32'd87654321);
    pending_ids.push_back(32'd9999999);
    pending_ids.push_back(32'd80000000);
    pending_ids.push_back(32'd8);
    pending_ids.push_back(32'hAAAA_AAAA);
    pending_ids.push_back(32'h5555_5555);
    pending_ids.push_back(32'h8000_0000);

    // Random items: half raw 32-bit, the rest digit-built or small.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 3))
        0, 1:    pending_ids.push_back($urandom());
        2:       pending_ids.push_back(decimal_id());
        default: pending_ids.push_back($urandom_range(0, 999));
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last item to go in, then for every owed hash to come out.
    while (pending_ids.size() > 0 || in_valid) @(posedge clk);
    while (owed_hashes.size() > 0) @(posedge clk);
    // Any stray result in the tail is caught by the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && owed_hashes.size() == 0) begin
      $display("decimal_digit_weighted_hash_top_tb: done, clean");
    end else begin
      $display("decimal_digit_weighted_hash_top_tb: done, errors");
    end
    $finish;
  end

endmodule
